// File: rtl/gt_pkg.sv
// Shared definitions for the gammatone band filter: widths, register codes,
// the quarter-wave sine table and the structs passed between the filter blocks.
// No dependencies.
`timescale 1ns / 1ps

package gt_pkg;

    localparam int MAX_STAGES      = 8;
    localparam int SINE_TABLE_BITS = 10;
    localparam int STATE_WIDTH     = 24;
    localparam int STATE_FRAC      = STATE_WIDTH - 4;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 18;
    localparam int COEF_FRAC   = 15;
    localparam int GAIN_W      = 16;
    localparam int GAIN_FRAC   = 12;
    localparam int PHASE_W     = 32;
    localparam int STAGE_CNT_W = 4;
    localparam int EFF_W       = $clog2(MAX_STAGES + 1);
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 3;

    localparam int QUARTER   = 1 << (SINE_TABLE_BITS - 2);
    localparam int QUARTER_W = SINE_TABLE_BITS - 2;

    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PHASE_STEP    = 3'd0,
        REG_COEF_REAL     = 3'd1,
        REG_COEF_IMAG     = 3'd2,
        REG_OUTPUT_GAIN   = 3'd3,
        REG_ACTIVE_STAGES = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic                          valid;
        logic                          clip;
        logic signed [STATE_WIDTH-1:0] re;
        logic signed [STATE_WIDTH-1:0] im;
    } gt_link_t;

    typedef struct packed {
        logic                       valid;
        logic                       clip;
        logic signed [SAMPLE_W-1:0] sample;
    } gt_result_t;

    typedef logic [SAMPLE_W-1:0] qtab_t [QUARTER];

    // Q15 sine of (pi/2 * q / QUARTER) from a Q30 Taylor series.
    function automatic logic [SAMPLE_W-1:0] quarter_sine(input logic [63:0] q);
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        x  = (PI_Q30 * q + 64'(QUARTER)) >> (SINE_TABLE_BITS - 1);
        x2 = (x * x) >> 30;
        t  = ONE_Q30;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd156;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd110;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd72;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd42;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd20;
        t  = ONE_Q30 - ((x2 * t) >> 30) / 64'd6;
        s  = (x * t) >> 30;
        s  = (s + 64'd16384) >> 15;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return s[SAMPLE_W-1:0];
    endfunction

    function automatic qtab_t build_qtab();
        qtab_t tab;
        for (int i = 0; i < QUARTER; i++)
        begin
            tab[i] = quarter_sine(64'(i));
        end
        return tab;
    endfunction

    localparam qtab_t QTAB = build_qtab();
    localparam logic [SAMPLE_W-1:0] QPEAK = quarter_sine(64'(QUARTER));

    // Full-turn sine from the quarter table by symmetry.
    function automatic logic signed [SAMPLE_W-1:0] sine_lookup(
        input logic [SINE_TABLE_BITS-1:0] idx);
        logic [QUARTER_W-1:0] q;
        logic [QUARTER_W-1:0] qn;
        logic [SAMPLE_W-1:0]  mag;
        q  = idx[QUARTER_W-1:0];
        qn = '0 - q;
        if (idx[SINE_TABLE_BITS-2])
        begin
            if (q == '0)
            begin
                mag = QPEAK;
            end
            else
            begin
                mag = QTAB[qn];
            end
        end
        else
        begin
            mag = QTAB[q];
        end
        if (idx[SINE_TABLE_BITS-1])
        begin
            return -$signed(mag);
        end
        return $signed(mag);
    endfunction

endpackage

// File: rtl/gt_mix_down.sv
// Oscillator and mix-down front end: phase accumulator, sine/cosine lookup
// and the complex product that feeds the first cell. Depends on gt_pkg.
`timescale 1ns / 1ps

module gt_mix_down (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [gt_pkg::SAMPLE_W-1:0]  sample,
    input  logic [gt_pkg::PHASE_W-1:0]          phase_step,
    output gt_pkg::gt_link_t                    link,
    output logic signed [gt_pkg::SAMPLE_W-1:0]  sin_val,
    output logic signed [gt_pkg::SAMPLE_W-1:0]  cos_val
);

    localparam int PROD_W   = 2 * gt_pkg::SAMPLE_W;
    localparam int DN_SHIFT = 30 - gt_pkg::STATE_FRAC;
    localparam logic signed [PROD_W-1:0] DN_HALF = PROD_W'(1) <<< (DN_SHIFT - 1);

    logic [gt_pkg::PHASE_W-1:0]          phase_acc_reg;
    logic [gt_pkg::SINE_TABLE_BITS-1:0]  idx_reg;
    logic signed [gt_pkg::SAMPLE_W-1:0]  x_reg;
    logic                                lookup_v_reg;
    logic                                prod_v_reg;
    logic signed [gt_pkg::SAMPLE_W-1:0]  sin_reg;
    logic signed [gt_pkg::SAMPLE_W-1:0]  cos_reg;
    logic signed [PROD_W-1:0]            prod_c_reg;
    logic signed [PROD_W-1:0]            prod_s_reg;
    gt_pkg::gt_link_t                    link_reg;

    logic signed [gt_pkg::SAMPLE_W-1:0]  sn;
    logic signed [gt_pkg::SAMPLE_W-1:0]  cs;
    logic signed [PROD_W-1:0]            re_sum;
    logic signed [PROD_W-1:0]            im_sum;
    logic signed [PROD_W-1:0]            re_sh;
    logic signed [PROD_W-1:0]            im_sh;

    always_comb
    begin
        sn     = gt_pkg::sine_lookup(idx_reg);
        cs     = gt_pkg::sine_lookup(idx_reg + gt_pkg::SINE_TABLE_BITS'(gt_pkg::QUARTER));
        re_sum = prod_c_reg + DN_HALF;
        im_sum = -prod_s_reg + DN_HALF;
        re_sh  = re_sum >>> DN_SHIFT;
        im_sh  = im_sum >>> DN_SHIFT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_acc_reg <= '0;
            lookup_v_reg  <= 1'b0;
            prod_v_reg    <= 1'b0;
            link_reg      <= '0;
        end
        else
        begin
            lookup_v_reg <= start;
            prod_v_reg   <= lookup_v_reg;
            if (start)
            begin
                phase_acc_reg <= phase_acc_reg + phase_step;
            end
            link_reg.valid <= prod_v_reg;
            link_reg.clip  <= 1'b0;
            link_reg.re    <= re_sh[gt_pkg::STATE_WIDTH-1:0];
            link_reg.im    <= im_sh[gt_pkg::STATE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= sample;
            idx_reg <= phase_acc_reg[gt_pkg::PHASE_W-1 -: gt_pkg::SINE_TABLE_BITS];
        end
        if (lookup_v_reg)
        begin
            sin_reg    <= sn;
            cos_reg    <= cs;
            prod_c_reg <= x_reg * cs;
            prod_s_reg <= x_reg * sn;
        end
    end

    assign link    = link_reg;
    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

// File: rtl/gt_cell.sv
// One first-order complex recursive stage of the filter chain, holding its own
// previous input and output. Links go via a_link_reg, link_reg. Depends on gt_pkg.
`timescale 1ns / 1ps

module gt_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              active,
    input  logic signed [gt_pkg::COEF_W-1:0]  coef_re,
    input  logic signed [gt_pkg::COEF_W-1:0]  coef_im,
    input  gt_pkg::gt_link_t                  link_in,
    output gt_pkg::gt_link_t                  link_out
);

    localparam int SW     = gt_pkg::STATE_WIDTH;
    localparam int DIFF_W = SW + 1;
    localparam int PROD_W = DIFF_W + gt_pkg::COEF_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic signed [SUM_W-1:0] ROUND_HALF = SUM_W'(1) <<< (gt_pkg::COEF_FRAC - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'((64'sd1 <<< (SW - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    logic signed [SW-1:0]     prev_in_re_reg;
    logic signed [SW-1:0]     prev_in_im_reg;
    logic signed [SW-1:0]     prev_out_re_reg;
    logic signed [SW-1:0]     prev_out_im_reg;
    logic signed [PROD_W-1:0] p_rr_reg;
    logic signed [PROD_W-1:0] p_ii_reg;
    logic signed [PROD_W-1:0] p_ri_reg;
    logic signed [PROD_W-1:0] p_ir_reg;
    gt_pkg::gt_link_t         a_link_reg;
    gt_pkg::gt_link_t         link_reg;

    logic signed [DIFF_W-1:0] dr;
    logic signed [DIFF_W-1:0] di;
    logic signed [SUM_W-1:0]  sum_re;
    logic signed [SUM_W-1:0]  sum_im;
    logic signed [SUM_W-1:0]  new_re_w;
    logic signed [SUM_W-1:0]  new_im_w;
    logic signed [SW-1:0]     new_re;
    logic signed [SW-1:0]     new_im;
    logic                     sat_re;
    logic                     sat_im;
    gt_pkg::gt_link_t         link_next;

    always_comb
    begin
        dr       = DIFF_W'(prev_in_re_reg) - DIFF_W'(prev_out_re_reg);
        di       = DIFF_W'(prev_in_im_reg) - DIFF_W'(prev_out_im_reg);
        sum_re   = SUM_W'(p_rr_reg) - SUM_W'(p_ii_reg) + ROUND_HALF;
        sum_im   = SUM_W'(p_ri_reg) + SUM_W'(p_ir_reg) + ROUND_HALF;
        new_re_w = (sum_re >>> gt_pkg::COEF_FRAC) + SUM_W'(prev_out_re_reg);
        new_im_w = (sum_im >>> gt_pkg::COEF_FRAC) + SUM_W'(prev_out_im_reg);
        sat_re   = 1'b0;
        sat_im   = 1'b0;
        new_re   = new_re_w[SW-1:0];
        new_im   = new_im_w[SW-1:0];
        if (new_re_w > SAT_HI)
        begin
            new_re = SAT_HI[SW-1:0];
            sat_re = 1'b1;
        end
        else if (new_re_w < SAT_LO)
        begin
            new_re = SAT_LO[SW-1:0];
            sat_re = 1'b1;
        end
        if (new_im_w > SAT_HI)
        begin
            new_im = SAT_HI[SW-1:0];
            sat_im = 1'b1;
        end
        else if (new_im_w < SAT_LO)
        begin
            new_im = SAT_LO[SW-1:0];
            sat_im = 1'b1;
        end
        link_next = a_link_reg;
        if (a_link_reg.valid && active)
        begin
            link_next.clip = a_link_reg.clip | sat_re | sat_im;
            link_next.re   = new_re;
            link_next.im   = new_im;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_in_re_reg  <= '0;
            prev_in_im_reg  <= '0;
            prev_out_re_reg <= '0;
            prev_out_im_reg <= '0;
            a_link_reg      <= '0;
            link_reg        <= '0;
        end
        else
        begin
            a_link_reg <= link_in;
            link_reg   <= link_next;
            if (a_link_reg.valid && active)
            begin
                prev_in_re_reg  <= a_link_reg.re;
                prev_in_im_reg  <= a_link_reg.im;
                prev_out_re_reg <= new_re;
                prev_out_im_reg <= new_im;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (link_in.valid)
        begin
            p_rr_reg <= dr * coef_re;
            p_ii_reg <= di * coef_im;
            p_ri_reg <= dr * coef_im;
            p_ir_reg <= di * coef_re;
        end
    end

    assign link_out = link_reg;

endmodule

// File: rtl/gt_mix_up.sv
// Mix-up back end: rotates the last stage output back to the band, applies
// the output gain and saturates to 16 bits. Depends on gt_pkg.
`timescale 1ns / 1ps

module gt_mix_up (
    input  logic                                clk,
    input  logic                                rst_n,
    input  gt_pkg::gt_link_t                    link_in,
    input  logic signed [gt_pkg::SAMPLE_W-1:0]  sin_val,
    input  logic signed [gt_pkg::SAMPLE_W-1:0]  cos_val,
    input  logic signed [gt_pkg::GAIN_W-1:0]    gain,
    output gt_pkg::gt_result_t                  result
);

    localparam int UP_PROD_W   = gt_pkg::SAMPLE_W + gt_pkg::STATE_WIDTH;
    localparam int UP_DIFF_W   = UP_PROD_W + 1;
    localparam int MIX_W       = UP_DIFF_W - gt_pkg::STATE_FRAC;
    localparam int GAIN_PROD_W = MIX_W + gt_pkg::GAIN_W;
    localparam logic signed [UP_DIFF_W-1:0] UP_HALF =
        UP_DIFF_W'(1) <<< (gt_pkg::STATE_FRAC - 1);
    localparam logic signed [GAIN_PROD_W-1:0] GAIN_HALF =
        GAIN_PROD_W'(1) <<< (gt_pkg::GAIN_FRAC - 1);
    localparam logic signed [GAIN_PROD_W-1:0] OUT_HI =
        GAIN_PROD_W'((64'sd1 <<< (gt_pkg::SAMPLE_W - 1)) - 64'sd1);
    localparam logic signed [GAIN_PROD_W-1:0] OUT_LO = -OUT_HI - GAIN_PROD_W'(1);

    logic signed [UP_PROD_W-1:0]   pc_reg;
    logic signed [UP_PROD_W-1:0]   ps_reg;
    logic signed [MIX_W-1:0]       mixed_reg;
    logic signed [GAIN_PROD_W-1:0] gp_reg;
    logic                          a_v_reg;
    logic                          b_v_reg;
    logic                          c_v_reg;
    logic                          a_clip_reg;
    logic                          b_clip_reg;
    logic                          c_clip_reg;
    gt_pkg::gt_result_t            result_reg;

    logic signed [UP_DIFF_W-1:0]   diff;
    logic signed [UP_DIFF_W-1:0]   diff_sh;
    logic signed [GAIN_PROD_W-1:0] g_sh;
    logic signed [gt_pkg::SAMPLE_W-1:0] y;
    logic                          y_sat;

    always_comb
    begin
        diff    = UP_DIFF_W'(pc_reg) - UP_DIFF_W'(ps_reg) + UP_HALF;
        diff_sh = diff >>> gt_pkg::STATE_FRAC;
        g_sh    = (gp_reg + GAIN_HALF) >>> gt_pkg::GAIN_FRAC;
        y       = g_sh[gt_pkg::SAMPLE_W-1:0];
        y_sat   = 1'b0;
        if (g_sh > OUT_HI)
        begin
            y     = OUT_HI[gt_pkg::SAMPLE_W-1:0];
            y_sat = 1'b1;
        end
        else if (g_sh < OUT_LO)
        begin
            y     = OUT_LO[gt_pkg::SAMPLE_W-1:0];
            y_sat = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg    <= 1'b0;
            b_v_reg    <= 1'b0;
            c_v_reg    <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            a_v_reg           <= link_in.valid;
            b_v_reg           <= a_v_reg;
            c_v_reg           <= b_v_reg;
            result_reg.valid  <= c_v_reg;
            result_reg.clip   <= c_clip_reg | y_sat;
            result_reg.sample <= y;
        end
    end

    always_ff @(posedge clk)
    begin
        pc_reg     <= cos_val * link_in.re;
        ps_reg     <= sin_val * link_in.im;
        a_clip_reg <= link_in.clip;
        mixed_reg  <= diff_sh[MIX_W-1:0];
        b_clip_reg <= a_clip_reg;
        gp_reg     <= mixed_reg * gain;
        c_clip_reg <= b_clip_reg;
    end

    assign result = result_reg;

endmodule

// File: rtl/gammatone_filter.sv
// Top level of the gammatone band filter: configuration registers, the
// mix-down front end, the chain of stage cells, the mix-up back end and a
// two-entry output buffer. Depends on gt_pkg, gt_mix_down, gt_cell, gt_mix_up.
`timescale 1ns / 1ps

// One sample is taken per transfer and gives one filtered sample with a clip
// flag. The next input transfer waits until the sample's result leaves the
// mix-up back end: every sample walks the whole chain of eight cells,
// whatever the active stage count, after the mix-down registers and before
// the mix-up registers, and its result then goes into the output buffer. The
// output buffer holds two results, so a new sample is taken while a result waits.

module gammatone_filter (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [15:0]                       s_tdata,   // sample_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // sample_out
    output logic [0:0]                        m_tuser,   // clipped
    input  logic                              cfg_wr_en,
    input  logic [gt_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [gt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    logic [gt_pkg::PHASE_W-1:0]         phase_step_reg;
    logic signed [gt_pkg::COEF_W-1:0]   coef_re_reg;
    logic signed [gt_pkg::COEF_W-1:0]   coef_im_reg;
    logic signed [gt_pkg::GAIN_W-1:0]   gain_reg;
    logic [gt_pkg::STAGE_CNT_W-1:0]     stages_reg;
    logic                               busy_reg;
    gt_pkg::gt_result_t                 head_reg;
    gt_pkg::gt_result_t                 skid_reg;

    logic [gt_pkg::EFF_W-1:0]           stages_eff;
    logic [gt_pkg::MAX_STAGES-1:0]      active;
    gt_pkg::gt_link_t                   link [gt_pkg::MAX_STAGES+1];
    logic signed [gt_pkg::SAMPLE_W-1:0] sin_val;
    logic signed [gt_pkg::SAMPLE_W-1:0] cos_val;
    gt_pkg::gt_result_t                 res;
    logic                               s_accept;
    logic                               pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= '0;
            coef_re_reg    <= '0;
            coef_im_reg    <= '0;
            gain_reg       <= 16'sd4096;
            stages_reg     <= 4'd4;
        end
        else if (cfg_wr_en)
        begin
            case (gt_pkg::cfg_reg_t'(cfg_index))
                gt_pkg::REG_PHASE_STEP:    phase_step_reg <= cfg_data[gt_pkg::PHASE_W-1:0];
                gt_pkg::REG_COEF_REAL:     coef_re_reg    <= cfg_data[gt_pkg::COEF_W-1:0];
                gt_pkg::REG_COEF_IMAG:     coef_im_reg    <= cfg_data[gt_pkg::COEF_W-1:0];
                gt_pkg::REG_OUTPUT_GAIN:   gain_reg       <= cfg_data[gt_pkg::GAIN_W-1:0];
                gt_pkg::REG_ACTIVE_STAGES: stages_reg     <= cfg_data[gt_pkg::STAGE_CNT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (stages_reg == '0)
        begin
            stages_eff = gt_pkg::EFF_W'(1);
        end
        else if (int'(stages_reg) > gt_pkg::MAX_STAGES)
        begin
            stages_eff = gt_pkg::EFF_W'(gt_pkg::MAX_STAGES);
        end
        else
        begin
            stages_eff = gt_pkg::EFF_W'(stages_reg);
        end
    end

    assign s_accept = s_tvalid && s_tready;
    assign s_tready = !busy_reg && !skid_reg.valid;
    assign pop      = head_reg.valid && m_tready;

    gt_mix_down u_mix_down (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (s_accept),
        .sample     ($signed(s_tdata)),
        .phase_step (phase_step_reg),
        .link       (link[0]),
        .sin_val    (sin_val),
        .cos_val    (cos_val)
    );

    for (genvar n = 0; n < gt_pkg::MAX_STAGES; n++)
    begin : g_cell
        assign active[n] = (gt_pkg::EFF_W'(n) < stages_eff);

        gt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .active   (active[n]),
            .coef_re  (coef_re_reg),
            .coef_im  (coef_im_reg),
            .link_in  (link[n]),
            .link_out (link[n+1])
        );
    end

    gt_mix_up u_mix_up (
        .clk     (clk),
        .rst_n   (rst_n),
        .link_in (link[gt_pkg::MAX_STAGES]),
        .sin_val (sin_val),
        .cos_val (cos_val),
        .gain    (gain_reg),
        .result  (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            head_reg <= '0;
            skid_reg <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (res.valid)
            begin
                busy_reg <= 1'b0;
            end

            if (!head_reg.valid || pop)
            begin
                if (skid_reg.valid)
                begin
                    head_reg <= skid_reg;
                    skid_reg <= res;
                end
                else
                begin
                    head_reg <= res;
                end
            end
            else if (res.valid)
            begin
                skid_reg <= res;
            end
        end
    end

    assign m_tvalid   = head_reg.valid;
    assign m_tdata    = head_reg.sample;
    assign m_tuser[0] = head_reg.clip;

    a_result_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> busy_reg)
        else $error("result without a sample in flight");

    a_no_buffer_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !skid_reg.valid)
        else $error("result arrived with the output buffer full");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> !s_tready)
        else $error("input ready right after a transfer");

endmodule

// File: dv/gammatone_filter_test.sv
// Self-checking testbench for gammatone_filter: a table of directed samples and register
// writes, then randomized register phases and sample streams, checked against a predictor.
// Depends on gt_pkg and the gammatone_filter RTL.
`timescale 1ns / 1ps

module gammatone_filter_test;

    import gt_pkg::*;

    localparam int ITEM_TARGET   = 1250;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT   = 4000;
    localparam int MAX_REPORTS   = 10;
    localparam int MAX_WAIT      = 11;
    localparam int ROM_SIZE      = 1 << SINE_TABLE_BITS;
    localparam int ROM_QUARTER   = ROM_SIZE / 4;
    localparam int MIX_SHIFT     = 2 * (SAMPLE_W - 1) - STATE_FRAC;
    localparam int PLAN_LEN      = 39;

    localparam logic [CFG_INDEX_W-1:0] UNMAPPED_REG_LO = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] UNMAPPED_REG_HI = 3'd7;

    localparam longint unsigned PI_FIX30   = 64'd3373259426;
    localparam longint unsigned UNIT_FIX30 = 64'd1 << 30;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       clipped;
    } band_out_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_SAMPLE_KNOWN
    } row_kind_t;

    typedef struct packed {
        row_kind_t              kind;
        logic [CFG_INDEX_W-1:0] index;
        logic [CFG_DATA_W-1:0]  value;
        band_out_t              known;
    } plan_row_t;

    localparam band_out_t QUIET = '{sample: '0, clipped: 1'b0};

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [SAMPLE_W-1:0]    s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [SAMPLE_W-1:0]    m_tdata;
    logic [0:0]             m_tuser;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Filter settings and state as the predictor sees them.
    logic [PHASE_W-1:0]     phase_step_reg = '0;
    longint                 coef_re        = 0;
    longint                 coef_im        = 0;
    longint                 gain_reg       = 4096;
    logic [STAGE_CNT_W-1:0] stage_reg      = 4'd4;
    logic [PHASE_W-1:0]     phase_acc      = '0;
    longint                 in_re  [MAX_STAGES] = '{default: 0};
    longint                 in_im  [MAX_STAGES] = '{default: 0};
    longint                 out_re [MAX_STAGES] = '{default: 0};
    longint                 out_im [MAX_STAGES] = '{default: 0};
    longint                 sine_rom [ROM_SIZE];

    band_out_t              filtered_due [$];
    int                     fault_count    = 0;
    int                     items_sent     = 0;
    int                     idle_cycles    = 0;
    bit                     src_gaps_on    = 1'b1;
    bit                     sink_stalls_on = 1'b1;

    // Sample rows carry the sample in the low bits of value.
    plan_row_t plan [PLAN_LEN] = '{
        '{ROW_SAMPLE_KNOWN, '0, 32'h0000_0000, QUIET},
        '{ROW_SAMPLE_KNOWN, '0, 32'h0000_7FFF, QUIET},
        '{ROW_SAMPLE_KNOWN, '0, 32'h0000_8000, QUIET},
        '{ROW_SAMPLE_KNOWN, '0, 32'h0000_FFFF, QUIET},
        '{ROW_WRITE, REG_COEF_REAL,     32'h0000_8000, QUIET},
        '{ROW_WRITE, REG_ACTIVE_STAGES, 32'h0000_0001, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_7FFF, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_8000, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_5555, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_AAAA, QUIET},
        '{ROW_WRITE, REG_PHASE_STEP,    32'h4000_0000, QUIET},
        '{ROW_WRITE, REG_COEF_REAL,     32'h0001_FFFF, QUIET},
        '{ROW_WRITE, REG_COEF_IMAG,     32'hFFFE_0000, QUIET},
        '{ROW_WRITE, REG_OUTPUT_GAIN,   32'h0000_7FFF, QUIET},
        '{ROW_WRITE, REG_ACTIVE_STAGES, 32'h0000_0008, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_7FFF, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_7FFF, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_8000, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_8000, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_3039, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_FFFF, QUIET},
        '{ROW_WRITE, REG_ACTIVE_STAGES, 32'hFFFF_FFF0, QUIET},
        '{ROW_WRITE, REG_OUTPUT_GAIN,   32'hFFFF_8000, QUIET},
        '{ROW_WRITE, REG_PHASE_STEP,    32'hFFFF_FFFF, QUIET},
        '{ROW_WRITE, UNMAPPED_REG_LO,   32'hFFFF_FFFF, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_7FFF, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_8000, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_0001, QUIET},
        '{ROW_WRITE, REG_ACTIVE_STAGES, 32'h0000_000F, QUIET},
        '{ROW_WRITE, REG_COEF_REAL,     32'h0000_4000, QUIET},
        '{ROW_WRITE, REG_COEF_IMAG,     32'h0000_2000, QUIET},
        '{ROW_WRITE, REG_OUTPUT_GAIN,   32'h0000_1000, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_7FFF, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_0000, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_8000, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_0064, QUIET},
        '{ROW_WRITE, REG_OUTPUT_GAIN,   32'h0000_0000, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_8000, QUIET},
        '{ROW_SAMPLE, '0, 32'h0000_7FFF, QUIET}
    };

    gammatone_filter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Q15 sine of a point in the first quarter turn, Taylor series in Q30.
    function automatic longint taylor_sine(input longint unsigned q);
        longint unsigned divs [6];
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned quarter;
        divs    = '{156, 110, 72, 42, 20, 6};
        quarter = ROM_QUARTER;
        x       = (PI_FIX30 * q + quarter) / (2 * quarter);
        x2      = (x * x) >> 30;
        t       = UNIT_FIX30;
        foreach (divs[k])
        begin
            t = UNIT_FIX30 - ((x2 * t) >> 30) / divs[k];
        end
        s = (x * t) >> 30;
        s = (s + 64'd16384) >> 15;
        if (s > 64'd32767)
        begin
            s = 64'd32767;
        end
        return longint'(s);
    endfunction

    function automatic longint round_shift(input longint v, input int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(input longint v, input int w, inout bit clip);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            clip = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            clip = 1'b1;
            return lo;
        end
        return v;
    endfunction

    function automatic void apply_reg(input logic [CFG_INDEX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PHASE_STEP:    phase_step_reg = data;
            REG_COEF_REAL:     coef_re = longint'($signed(data[COEF_W-1:0]));
            REG_COEF_IMAG:     coef_im = longint'($signed(data[COEF_W-1:0]));
            REG_OUTPUT_GAIN:   gain_reg = longint'($signed(data[GAIN_W-1:0]));
            REG_ACTIVE_STAGES: stage_reg = data[STAGE_CNT_W-1:0];
            default:           ;
        endcase
    endfunction

    function automatic band_out_t filter_step(input logic signed [SAMPLE_W-1:0] x_in);
        band_out_t                  res;
        logic [SINE_TABLE_BITS-1:0] s_idx;
        logic [SINE_TABLE_BITS-1:0] c_idx;
        longint                     x;
        longint                     sn;
        longint                     cs;
        longint                     re;
        longint                     im;
        longint                     dr;
        longint                     di;
        longint                     pr;
        longint                     pq;
        longint                     nr;
        longint                     ni;
        longint                     mixed;
        int                         stages;
        bit                         clip;
        x      = x_in;
        s_idx  = phase_acc[PHASE_W-1 -: SINE_TABLE_BITS];
        c_idx  = s_idx + SINE_TABLE_BITS'(ROM_QUARTER);
        sn     = sine_rom[s_idx];
        cs     = sine_rom[c_idx];
        stages = int'(stage_reg);
        if (stages < 1)
        begin
            stages = 1;
        end
        if (stages > MAX_STAGES)
        begin
            stages = MAX_STAGES;
        end
        clip = 1'b0;
        re   = round_shift(x * cs, MIX_SHIFT);
        im   = round_shift(-(x * sn), MIX_SHIFT);
        for (int n = 0; n < stages; n++)
        begin
            dr = in_re[n] - out_re[n];
            di = in_im[n] - out_im[n];
            pr = round_shift(dr * coef_re - di * coef_im, COEF_FRAC);
            pq = round_shift(dr * coef_im + di * coef_re, COEF_FRAC);
            nr = clamp(out_re[n] + pr, STATE_WIDTH, clip);
            ni = clamp(out_im[n] + pq, STATE_WIDTH, clip);
            in_re[n]  = re;
            in_im[n]  = im;
            out_re[n] = nr;
            out_im[n] = ni;
            re = nr;
            im = ni;
        end
        mixed       = round_shift(cs * re - sn * im, STATE_FRAC);
        res.sample  = SAMPLE_W'(clamp(round_shift(mixed * gain_reg, GAIN_FRAC), SAMPLE_W, clip));
        res.clipped = clip;
        phase_acc   = phase_acc + phase_step_reg;
        return res;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coef(input bit real_part);
        logic [CFG_DATA_W-1:0] data;
        data = $urandom;
        case ($urandom_range(9, 0))
            0:       ;
            1:       data[COEF_W-1:0] = {1'b0, {(COEF_W - 1){1'b1}}};
            2:       data[COEF_W-1:0] = {1'b1, {(COEF_W - 1){1'b0}}};
            default: data[COEF_W-1:0] = real_part ? COEF_W'($urandom_range(32768, 0))
                                                  : COEF_W'(int'($urandom_range(16384, 0)) - 8192);
        endcase
        return data;
    endfunction

    function automatic void note_fault(input string what, input band_out_t want,
                                       input band_out_t got);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
        begin
            $display("%0t: %s: expected sample %0d clipped %0b, got sample %0d clipped %0b",
                     $time, what, want.sample, want.clipped, got.sample, got.clipped);
        end
    endfunction

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (filtered_due.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic reg_write(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        apply_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic send_sample(input logic [SAMPLE_W-1:0] value, input bit known,
                               input band_out_t known_out);
        int        gap;
        band_out_t want;
        gap = src_gaps_on ? $urandom_range(MAX_WAIT, 0) : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        do
        begin
            @(posedge clk);
        end
        while (!s_tready);
        want = filter_step(value);
        filtered_due.push_back(known ? known_out : want);
        items_sent++;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        band_out_t want;
        band_out_t got;
        int        stall;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            stall = sink_stalls_on ? $urandom_range(MAX_WAIT, 0) : 0;
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready <= 1'b1;
            do
            begin
                @(posedge clk);
            end
            while (!m_tvalid);
            got.sample  = m_tdata;
            got.clipped = m_tuser[0];
            if (filtered_due.size() == 0)
            begin
                note_fault("result with nothing expected", QUIET, got);
            end
            else
            begin
                want = filtered_due.pop_front();
                if (got.sample !== want.sample || got.clipped !== want.clipped)
                begin
                    note_fault("result mismatch", want, got);
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin
        logic [CFG_DATA_W-1:0] data;
        logic [SAMPLE_W-1:0]   smp;
        int                    quad;
        int                    qpos;
        longint                mag;
        int                    burst;
        bit                    writing;

        for (int i = 0; i < ROM_SIZE; i++)
        begin
            quad        = i / ROM_QUARTER;
            qpos        = i % ROM_QUARTER;
            mag         = quad[0] ? taylor_sine(ROM_QUARTER - qpos) : taylor_sine(qpos);
            sine_rom[i] = quad[1] ? -mag : mag;
        end

        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        writing = 1'b0;
        foreach (plan[r])
        begin
            if (plan[r].kind == ROW_WRITE)
            begin
                if (!writing)
                begin
                    quiesce();
                end
                writing = 1'b1;
                reg_write(plan[r].index, plan[r].value);
            end
            else
            begin
                if (writing)
                begin
                    cfg_wr_en <= 1'b0;
                end
                writing = 1'b0;
                send_sample(plan[r].value[SAMPLE_W-1:0], plan[r].kind == ROW_SAMPLE_KNOWN,
                            plan[r].known);
            end
        end

        while (items_sent < ITEM_TARGET)
        begin
            quiesce();
            src_gaps_on    = ($urandom_range(3, 0) != 0);
            sink_stalls_on = ($urandom_range(3, 0) != 0);
            if ($urandom_range(1, 0) != 0)
            begin
                data = $urandom;
                case ($urandom_range(4, 0))
                    0:       data = '0;
                    1:       data = '1;
                    2:       data = data >> 8;
                    default: ;
                endcase
                reg_write(REG_PHASE_STEP, data);
            end
            if ($urandom_range(1, 0) != 0)
            begin
                reg_write(REG_COEF_REAL, pick_coef(1'b1));
            end
            if ($urandom_range(1, 0) != 0)
            begin
                reg_write(REG_COEF_IMAG, pick_coef(1'b0));
            end
            if ($urandom_range(1, 0) != 0)
            begin
                data = $urandom;
                case ($urandom_range(4, 0))
                    0:       ;
                    1:       data[GAIN_W-1:0] = {1'b1, {(GAIN_W - 1){1'b0}}};
                    2:       data[GAIN_W-1:0] = {1'b0, {(GAIN_W - 1){1'b1}}};
                    default: data[GAIN_W-1:0] = GAIN_W'($urandom_range(8192, 1024));
                endcase
                reg_write(REG_OUTPUT_GAIN, data);
            end
            if ($urandom_range(1, 0) != 0)
            begin
                data = $urandom;
                if ($urandom_range(1, 0) != 0)
                begin
                    data[STAGE_CNT_W-1:0] = STAGE_CNT_W'($urandom_range(MAX_STAGES, 1));
                end
                reg_write(REG_ACTIVE_STAGES, data);
            end
            if ($urandom_range(7, 0) == 0)
            begin
                reg_write(CFG_INDEX_W'($urandom_range(UNMAPPED_REG_HI, UNMAPPED_REG_LO)),
                          $urandom);
            end
            cfg_wr_en <= 1'b0;

            burst = $urandom_range(120, 20);
            for (int k = 0; k < burst && items_sent < ITEM_TARGET; k++)
            begin
                case ($urandom_range(7, 0))
                    0:       smp = ($urandom_range(1, 0) != 0) ? 16'h7FFF : 16'h8000;
                    1, 2:    smp = SAMPLE_W'(int'($urandom_range(2047, 0)) - 1024);
                    default: smp = $urandom;
                endcase
                send_sample(smp, 1'b0, QUIET);
            end
        end

        quiesce();
        if (fault_count == 0 && filtered_due.size() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
